// File: design/png_scanline_unfilter_assert.svh
// ----------------------------------------------------------------------------
// png_scanline_unfilter_assert.svh
// Assertion macros used by the checker of the scanline unfilter.
// ----------------------------------------------------------------------------
`ifndef PNG_SCANLINE_UNFILTER_ASSERT_SVH
`define PNG_SCANLINE_UNFILTER_ASSERT_SVH

// next-cycle implication that is also checked while reset is high
`define PSU_CHECK_NEXT(name, clk, ante, cons, msg) \
   name: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error(msg);

// next-cycle implication that is switched off during reset
`define PSU_CHECK_NEXT_RST(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: design/png_unf_pkg.sv
// ----------------------------------------------------------------------------
// png_unf_pkg
// Types and constants shared by the PNG scanline unfilter modules.
// ----------------------------------------------------------------------------
package png_unf_pkg;

   // fixed field widths
   localparam int DATA_W        = 8;
   localparam int ROW_BYTES_W   = 14;
   localparam int PIXEL_BYTES_W = 4;
   localparam int IDX_W         = 16;
   localparam int SEL_W         = 3;

   // highest legal filter type code
   localparam logic [DATA_W-1:0] FILTER_MAX = 8'd4;

   // filter types of PNG filter method 0
   typedef enum logic [2:0] {
      FILTER_NONE    = 3'd0,
      FILTER_SUB     = 3'd1,
      FILTER_UP      = 3'd2,
      FILTER_AVERAGE = 3'd3,
      FILTER_PAETH   = 3'd4
   } filter_kind_type;

   // configuration register indexes
   typedef enum logic [0:0] {
      CSR_ROW_BYTES       = 1'b0,
      CSR_BYTES_PER_PIXEL = 1'b1
   } csr_reg_type;

   // configuration as seen by the front end
   typedef struct packed {
      logic [ROW_BYTES_W-1:0]   row_bytes;
      logic [PIXEL_BYTES_W-1:0] bytes_per_pixel;
   } cfg_type;

   // classified sample item handed from front to back
   typedef struct packed {
      logic [DATA_W-1:0] data;
      logic [IDX_W-1:0]  idx;
      filter_kind_type   filter;
      logic              first_row;
      logic              has_left;
      logic              last;
      logic              bad_filter;
      logic [SEL_W-1:0]  left_sel;
   } sample_item_type;

   // reconstructed result item
   typedef struct packed {
      logic [DATA_W-1:0] pixel_byte;
      logic              row_end;
      logic              bad_filter;
   } result_item_type;

endpackage

// File: design/png_unf_fifo.sv
// ----------------------------------------------------------------------------
// png_unf_fifo
// Small register-based first-in first-out queue with a fill count.
// ----------------------------------------------------------------------------
module png_unf_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  logic [WIDTH-1:0]           push_data,
   input  logic                       pop,
   output logic [WIDTH-1:0]           pop_data,
   output logic                       full,
   output logic                       empty,
   output logic [$clog2(DEPTH+1)-1:0] count
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   // status
   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign count    = count_ff;
   assign pop_data = mem_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   // pointer and count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// File: design/png_unf_front.sv
// ----------------------------------------------------------------------------
// png_unf_front
// Accepts stream bytes, walks the row, decodes filter bytes and hands each
// sample byte with its row context to the back end.
// ----------------------------------------------------------------------------
module png_unf_front #(
   parameter int MAX_ROW_BYTES   = 8192,
   parameter int MAX_PIXEL_BYTES = 8
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_push,
   output logic                          req_full,
   input  logic [png_unf_pkg::DATA_W-1:0] req_data_byte,
   input  logic                          req_start_of_image,
   input  png_unf_pkg::cfg_type          cfg,
   output logic                          q_push,
   output png_unf_pkg::sample_item_type  q_data,
   input  logic                          q_full
);

   import png_unf_pkg::*;

   localparam int POS_W = $clog2(MAX_ROW_BYTES + 1);
   localparam int AW    = $clog2(MAX_ROW_BYTES);
   localparam int LEN_W = (POS_W > ROW_BYTES_W) ? POS_W : ROW_BYTES_W;

   logic [POS_W-1:0]         row_position_ff, row_position_in;
   filter_kind_type          filter_ff, filter_in;
   logic                     first_row_ff, first_row_in;
   logic                     error_ff, error_in;

   logic                     accept;
   logic [LEN_W-1:0]         rb_raw, rb_eff;
   logic [PIXEL_BYTES_W-1:0] bpp_eff, bpp_m1;
   logic [POS_W-1:0]         pos, idx_wide;
   logic [AW-1:0]            idx;
   logic                     first, err, last, bad_type;

   assign accept   = req_push && !q_full;
   assign req_full = q_full;

   // clamp the configuration to the supported ranges
   always_comb begin
      rb_raw = LEN_W'(cfg.row_bytes);
      if (rb_raw == '0) begin
         rb_eff = LEN_W'(1);
      end else if (rb_raw > LEN_W'(MAX_ROW_BYTES)) begin
         rb_eff = LEN_W'(MAX_ROW_BYTES);
      end else begin
         rb_eff = rb_raw;
      end
      if (cfg.bytes_per_pixel == '0) begin
         bpp_eff = PIXEL_BYTES_W'(1);
      end else if (cfg.bytes_per_pixel > PIXEL_BYTES_W'(MAX_PIXEL_BYTES)) begin
         bpp_eff = PIXEL_BYTES_W'(MAX_PIXEL_BYTES);
      end else begin
         bpp_eff = cfg.bytes_per_pixel;
      end
      bpp_m1 = bpp_eff - 1'b1;
   end

   // row context seen by this byte, start of image restarts the walk
   always_comb begin
      pos      = req_start_of_image ? '0 : row_position_ff;
      first    = req_start_of_image || first_row_ff;
      err      = !req_start_of_image && error_ff;
      idx_wide = pos - 1'b1;
      idx      = idx_wide[AW-1:0];
      last     = LEN_W'(pos) >= rb_eff;
      bad_type = req_data_byte > FILTER_MAX;
   end

   // classify the byte and update the row walk
   always_comb begin
      row_position_in = row_position_ff;
      filter_in       = filter_ff;
      first_row_in    = first_row_ff;
      error_in        = error_ff;
      q_push          = 1'b0;

      q_data.data       = req_data_byte;
      q_data.idx        = IDX_W'(idx);
      q_data.filter     = filter_ff;
      q_data.first_row  = first;
      q_data.has_left   = IDX_W'(idx) >= IDX_W'(bpp_eff);
      q_data.last       = last;
      q_data.bad_filter = err;
      q_data.left_sel   = bpp_m1[SEL_W-1:0];

      if (accept) begin
         first_row_in = first;
         error_in     = err;
         if (pos == '0) begin
            // filter type byte
            row_position_in = POS_W'(1);
            if (bad_type) begin
               filter_in = FILTER_NONE;
               error_in  = 1'b1;
            end else begin
               filter_in = filter_kind_type'(req_data_byte[2:0]);
            end
         end else begin
            // sample byte
            q_push = 1'b1;
            if (last) begin
               row_position_in = '0;
               first_row_in    = 1'b0;
            end else begin
               row_position_in = pos + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_position_ff <= '0;
         filter_ff       <= FILTER_NONE;
         first_row_ff    <= 1'b1;
         error_ff        <= 1'b0;
      end else begin
         row_position_ff <= row_position_in;
         filter_ff       <= filter_in;
         first_row_ff    <= first_row_in;
         error_ff        <= error_in;
      end
   end

endmodule

// File: design/png_unf_back.sv
// ----------------------------------------------------------------------------
// png_unf_back
// Reconstructs sample bytes: reads the previous-row buffer, applies the
// predictor and writes the result back to the row buffer and out.
// ----------------------------------------------------------------------------
module png_unf_back #(
   parameter int MAX_ROW_BYTES   = 8192,
   parameter int MAX_PIXEL_BYTES = 8,
   parameter int OUT_DEPTH       = 4
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             q_empty,
   input  png_unf_pkg::sample_item_type     q_data,
   output logic                             q_pop,
   input  logic [$clog2(OUT_DEPTH+1)-1:0]   o_count,
   output logic                             res_push,
   output png_unf_pkg::result_item_type     res_data
);

   import png_unf_pkg::*;

   localparam int AW    = $clog2(MAX_ROW_BYTES);
   localparam int SW    = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1;
   localparam int CNT_W = $clog2(OUT_DEPTH + 1);

   // paeth predictor
   function automatic logic [DATA_W-1:0] paeth_pred(input logic [DATA_W-1:0] a,
                                                    input logic [DATA_W-1:0] b,
                                                    input logic [DATA_W-1:0] c);
      logic [9:0] pa, pb, pc, sum_ab, two_c;
      logic [DATA_W-1:0] pick;
      pa     = (b > c) ? 10'(b - c) : 10'(c - b);
      pb     = (a > c) ? 10'(a - c) : 10'(c - a);
      sum_ab = 10'(a) + 10'(b);
      two_c  = {1'b0, c, 1'b0};
      pc     = (sum_ab > two_c) ? sum_ab - two_c : two_c - sum_ab;
      if (pa <= pb && pa <= pc) begin
         pick = a;
      end else if (pb <= pc) begin
         pick = b;
      end else begin
         pick = c;
      end
      return pick;
   endfunction

   logic [DATA_W-1:0]   row_mem [MAX_ROW_BYTES];
   logic [DATA_W-1:0]   rd_data_ff;
   logic                s2_valid_ff;
   sample_item_type     s2_item_ff;
   logic                fwd_hit_ff, fwd_hit_in;
   logic [DATA_W-1:0]   fwd_data_ff;
   logic [DATA_W-1:0]   left_ff [MAX_PIXEL_BYTES];
   logic [DATA_W-1:0]   upleft_ff [MAX_PIXEL_BYTES];

   logic [CNT_W:0]      pending;
   logic [AW-1:0]       q_idx, s2_idx;
   logic [SW-1:0]       sel;
   logic [DATA_W-1:0]   a, b, c, pred, res;
   logic [DATA_W:0]     avg_sum;

   // issue when the result queue has room for everything in flight
   assign pending = (CNT_W+1)'(o_count) + (CNT_W+1)'(s2_valid_ff);
   assign q_pop   = !q_empty && (pending < (CNT_W+1)'(OUT_DEPTH));
   assign q_idx   = q_data.idx[AW-1:0];
   assign s2_idx  = s2_item_ff.idx[AW-1:0];

   // a write in this cycle to the address being read is forwarded
   assign fwd_hit_in = s2_valid_ff && (q_idx == s2_idx);

   // row buffer: one read and one write a cycle
   always_ff @(posedge clock) begin
      if (s2_valid_ff) begin
         row_mem[s2_idx] <= res;
      end
      if (q_pop) begin
         rd_data_ff <= row_mem[q_idx];
      end
   end

   // stage two control
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= q_pop;
      end
   end

   // stage two payload
   always_ff @(posedge clock) begin
      if (q_pop) begin
         s2_item_ff  <= q_data;
         fwd_hit_ff  <= fwd_hit_in;
         fwd_data_ff <= res;
      end
   end

   // neighbors and predictor
   always_comb begin
      sel = s2_item_ff.left_sel[SW-1:0];
      if (s2_item_ff.first_row) begin
         b = '0;
      end else if (fwd_hit_ff) begin
         b = fwd_data_ff;
      end else begin
         b = rd_data_ff;
      end
      a = s2_item_ff.has_left ? left_ff[sel] : '0;
      c = (s2_item_ff.has_left && !s2_item_ff.first_row) ? upleft_ff[sel] : '0;
      avg_sum = (DATA_W+1)'(a) + (DATA_W+1)'(b);
      case (s2_item_ff.filter)
         FILTER_SUB:     pred = a;
         FILTER_UP:      pred = b;
         FILTER_AVERAGE: pred = avg_sum[DATA_W:1];
         FILTER_PAETH:   pred = paeth_pred(a, b, c);
         default:        pred = '0;
      endcase
      res = s2_item_ff.data + pred;
   end

   // history of the current row, newest first
   always_ff @(posedge clock) begin
      if (s2_valid_ff) begin
         left_ff[0]   <= res;
         upleft_ff[0] <= b;
         for (int k = 1; k < MAX_PIXEL_BYTES; k++) begin
            left_ff[k]   <= left_ff[k-1];
            upleft_ff[k] <= upleft_ff[k-1];
         end
      end
   end

   // result out
   assign res_push            = s2_valid_ff;
   assign res_data.pixel_byte = res;
   assign res_data.row_end    = s2_item_ff.last;
   assign res_data.bad_filter = s2_item_ff.bad_filter;

endmodule

// File: design/png_scanline_unfilter.sv
// ----------------------------------------------------------------------------
// png_scanline_unfilter
// PNG filter method 0 reconstruction over an inflated byte stream.
// ----------------------------------------------------------------------------
// Takes one byte per cycle: the first byte of each row is the filter type and
// gives no result, each following sample byte gives one reconstructed byte,
// flagged on the last byte of the row and carrying the sticky bad-filter flag.
// Sustained rate is one item per clock while req_full is low; a sample reaches
// the result side through the sample queue, the row buffer read (issue) and
// the predictor stage writing the result queue. The row buffer is a
// single memory of MAX_ROW_BYTES bytes, read and written once per cycle; it
// needs no clearing pass, since the first row of an image never uses it.
// Configuration (row_bytes, bytes_per_pixel) may only be written while idle.
// ----------------------------------------------------------------------------
module png_scanline_unfilter #(
   parameter int MAX_ROW_BYTES   = 8192,
   parameter int MAX_PIXEL_BYTES = 8,
   parameter int QUEUE_DEPTH     = 4,
   parameter int OUT_DEPTH       = 4
) (
   input  logic                                clock,
   input  logic                                reset,
   // input items
   input  logic                                req_push,
   output logic                                req_full,
   input  logic [png_unf_pkg::DATA_W-1:0]      req_data_byte,
   input  logic                                req_start_of_image,
   // result items
   output logic                                rsp_empty,
   input  logic                                rsp_pop,
   output logic [png_unf_pkg::DATA_W-1:0]      rsp_pixel_byte,
   output logic                                rsp_row_end,
   output logic                                rsp_bad_filter,
   // register writes
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [0:0]                          csr_index,
   input  logic [png_unf_pkg::ROW_BYTES_W-1:0] csr_wdata
);

   import png_unf_pkg::*;

   localparam int SAMPLE_W = $bits(sample_item_type);
   localparam int RESULT_W = $bits(result_item_type);

   logic [ROW_BYTES_W-1:0]         row_bytes_ff, row_bytes_in;
   logic [PIXEL_BYTES_W-1:0]       bpp_ff, bpp_in;
   cfg_type                        cfg;

   logic                           q_push, q_pop, q_full, q_empty;
   sample_item_type                q_in_item, q_out_item;
   logic [SAMPLE_W-1:0]            q_out_bits;

   logic                           res_push;
   result_item_type                res_item, rsp_item;
   logic [RESULT_W-1:0]            o_out_bits;
   logic [$clog2(OUT_DEPTH+1)-1:0] o_count;

   // configuration registers
   assign csr_ready = 1'b1;

   always_comb begin
      row_bytes_in = row_bytes_ff;
      bpp_in       = bpp_ff;
      if (csr_valid) begin
         unique case (csr_reg_type'(csr_index))
            CSR_ROW_BYTES:       row_bytes_in = csr_wdata;
            CSR_BYTES_PER_PIXEL: bpp_in       = csr_wdata[PIXEL_BYTES_W-1:0];
            default:             row_bytes_in = row_bytes_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_bytes_ff <= ROW_BYTES_W'(1);
         bpp_ff       <= PIXEL_BYTES_W'(1);
      end else begin
         row_bytes_ff <= row_bytes_in;
         bpp_ff       <= bpp_in;
      end
   end

   assign cfg.row_bytes       = row_bytes_ff;
   assign cfg.bytes_per_pixel = bpp_ff;

   // front end: row walk and classification
   png_unf_front #(
      .MAX_ROW_BYTES   (MAX_ROW_BYTES),
      .MAX_PIXEL_BYTES (MAX_PIXEL_BYTES)
   ) u_front (
      .clock              (clock),
      .reset              (reset),
      .req_push           (req_push),
      .req_full           (req_full),
      .req_data_byte      (req_data_byte),
      .req_start_of_image (req_start_of_image),
      .cfg                (cfg),
      .q_push             (q_push),
      .q_data             (q_in_item),
      .q_full             (q_full)
   );

   // sample queue between front and back
   png_unf_fifo #(
      .WIDTH (SAMPLE_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_sample_q (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_in_item),
      .pop       (q_pop),
      .pop_data  (q_out_bits),
      .full      (q_full),
      .empty     (q_empty),
      .count     ()
   );

   assign q_out_item = sample_item_type'(q_out_bits);

   // back end: reconstruction
   png_unf_back #(
      .MAX_ROW_BYTES   (MAX_ROW_BYTES),
      .MAX_PIXEL_BYTES (MAX_PIXEL_BYTES),
      .OUT_DEPTH       (OUT_DEPTH)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .q_empty  (q_empty),
      .q_data   (q_out_item),
      .q_pop    (q_pop),
      .o_count  (o_count),
      .res_push (res_push),
      .res_data (res_item)
   );

   // result queue, the back end only issues when it has room
   png_unf_fifo #(
      .WIDTH (RESULT_W),
      .DEPTH (OUT_DEPTH)
   ) u_result_q (
      .clock     (clock),
      .reset     (reset),
      .push      (res_push),
      .push_data (res_item),
      .pop       (rsp_pop),
      .pop_data  (o_out_bits),
      .full      (),
      .empty     (rsp_empty),
      .count     (o_count)
   );

   assign rsp_item       = result_item_type'(o_out_bits);
   assign rsp_pixel_byte = rsp_item.pixel_byte;
   assign rsp_row_end    = rsp_item.row_end;
   assign rsp_bad_filter = rsp_item.bad_filter;

endmodule

// File: design/png_unf_checker.sv
// ----------------------------------------------------------------------------
// png_unf_checker
// Port-level checks of the scanline unfilter, bound to the top level.
// ----------------------------------------------------------------------------
`include "png_scanline_unfilter_assert.svh"

module png_unf_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_push,
   input logic       req_full,
   input logic       rsp_empty,
   input logic       rsp_pop,
   input logic [7:0] rsp_pixel_byte,
   input logic       rsp_row_end,
   input logic       rsp_bad_filter
);

   // reset leaves no result behind
   `PSU_CHECK_NEXT(a_reset_empty, clock, reset, rsp_empty, "result waiting after reset")

   // reset leaves the input side open
   `PSU_CHECK_NEXT(a_reset_open, clock, reset, !req_full, "input full after reset")

   // a waiting result holds until taken
   `PSU_CHECK_NEXT_RST(a_rsp_hold, clock, reset, !rsp_empty && !rsp_pop, !rsp_empty && $stable(rsp_pixel_byte) && $stable(rsp_row_end) && $stable(rsp_bad_filter), "waiting result changed")

endmodule

bind png_scanline_unfilter png_unf_checker u_checker (.*);
